// File: hdl/i2cm_pkg.sv
// shared types and constants of the i2c master bit engine
`default_nettype none

package i2cm_pkg;

    localparam int HALF_W    = 16;
    localparam int TMO_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(5);
    localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(250);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO  = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4,
        ACT_WAIT  = 3'd5
    } t_action;

    typedef struct packed {
        logic [HALF_W-1:0] half_period;
        logic [TMO_W-1:0]  ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } t_item;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_failed;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/i2c_master_bit_engine_core.sv
// top level of the i2c master bit engine: request registers, config, result register
// an accepted request waits in the request register until the result register is free;
// throughput: one request per cycle unless i_ready stalls, one result per request; the
// sequencer update is a single registered step between request and result registers
// reset: synchronous active low; clears handshake state, sequencer goes idle with
// scl and sda released, half_period returns to 5 and ack_timeout to 250
`default_nettype none

module i2c_master_bit_engine_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request channel
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [i2cm_pkg::ACT_W-1:0]           i_action,
    input  wire logic [i2cm_pkg::BYTE_W-1:0]          i_tx_byte,
    input  wire logic                                 i_send_ack,
    input  wire logic                                 i_sda_in,
    // result channel
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic                                      o_scl_level,
    output logic                                      o_sda_level,
    output logic                                      o_busy_res,
    output logic                                      o_done_res,
    output logic [i2cm_pkg::BYTE_W-1:0]               o_rx_byte,
    output logic                                      o_ack_failed,
    // configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [i2cm_pkg::CFG_W-1:0]           i_cfg_data
);
    import i2cm_pkg::*;

    // configuration registers
    t_cfg    r_cfg;

    // request stage
    logic    r_in_vld;
    t_item   r_in;

    // result stage
    logic    r_out_vld;
    t_result r_out;

    t_result res;
    logic    step;
    logic    accept;

    // a held request advances once the result register is free or draining
    assign step    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || step;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period <= HALF_RST;
            r_cfg.ack_timeout <= TMO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF: r_cfg.half_period <= i_cfg_data;
                CFG_TMO:  r_cfg.ack_timeout <= i_cfg_data[TMO_W-1:0];
                default:  begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.action   <= i_action;
            r_in.tx_byte  <= i_tx_byte;
            r_in.send_ack <= i_send_ack;
            r_in.sda_in   <= i_sda_in;
        end
    end

    // sequencer: one tick of bus timing per request
    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_scl_level  = r_out.scl_level;
    assign o_sda_level  = r_out.sda_level;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_rx_byte    = r_out.rx_byte;
    assign o_ack_failed = r_out.ack_failed;

endmodule

`default_nettype wire

// File: hdl/i2cm_seq.sv
// bus sequencer: state registers and one-tick next-state logic
`default_nettype none

module i2cm_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire i2cm_pkg::t_cfg  i_cfg,
    input  wire i2cm_pkg::t_item i_item,
    output i2cm_pkg::t_result    o_res
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_P3, PH_WLOW, PH_WHIGH,
        PH_WTAIL, PH_RLOW, PH_RHIGH, PH_ALOW, PH_AHIGH, PH_KREL, PH_KHOLD, PH_KPOLL
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_bit, n_bit;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic [HALF_W-1:0]  r_delay, n_delay;
    logic [TMO_W-1:0]   r_wait, n_wait;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic [BYTE_W-1:0]  r_rx, n_rx;
    logic               r_ackc, n_ackc;
    logic               r_fail, n_fail;
    logic               done;

    logic [HALF_W-1:0]  hp;
    logic [3:0]         bit_inc;
    logic [TMO_W-1:0]   wait_inc;

    assign hp       = (i_cfg.half_period == '0) ? HALF_W'(1) : i_cfg.half_period;
    assign bit_inc  = r_bit + 4'd1;
    assign wait_inc = r_wait + TMO_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_delay = r_delay;
        n_wait  = r_wait;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_ackc  = r_ackc;
        n_fail  = r_fail;
        done    = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (t_action'(i_item.action))
                ACT_START: begin
                    n_sda = 1'b1; n_scl = 1'b1;
                    n_phase = PH_S1; n_delay = hp;
                end
                ACT_STOP: begin
                    n_sda = 1'b0; n_scl = 1'b0;
                    n_phase = PH_P1; n_delay = hp;
                end
                ACT_WRITE: begin
                    n_scl = 1'b0;
                    n_sda = i_item.tx_byte[BYTE_W-1];
                    n_shift = {i_item.tx_byte[BYTE_W-2:0], 1'b0};
                    n_bit = '0;
                    n_phase = PH_WLOW; n_delay = hp;
                end
                ACT_READ: begin
                    n_scl = 1'b0; n_sda = 1'b1; n_shift = '0; n_bit = '0;
                    n_ackc = i_item.send_ack;
                    n_phase = PH_RLOW; n_delay = hp;
                end
                ACT_WAIT: begin
                    n_sda = 1'b1; n_wait = '0; n_fail = 1'b0;
                    n_phase = PH_KREL; n_delay = HALF_W'(1);
                end
                default: begin
                end
            endcase
        end else if (r_phase == PH_KPOLL) begin
            if (!i_item.sda_in) begin
                // slave acknowledged
                n_scl = 1'b0;
                n_phase = PH_IDLE; n_delay = '0; done = 1'b1;
            end else begin
                n_wait = wait_inc;
                if (wait_inc >= i_cfg.ack_timeout) begin
                    n_fail = 1'b1;
                    n_scl = 1'b0; n_sda = 1'b0;
                    n_phase = PH_P1; n_delay = hp;
                end
            end
        end else if (r_delay > HALF_W'(1)) begin
            n_delay = r_delay - HALF_W'(1);
        end else begin
            unique case (r_phase)
                PH_S1:    begin n_sda = 1'b0; n_phase = PH_S2; n_delay = hp; end
                PH_P1:    begin n_scl = 1'b1; n_phase = PH_P2; n_delay = hp; end
                PH_P2:    begin n_sda = 1'b1; n_phase = PH_P3; n_delay = hp; end
                PH_WLOW:  begin n_scl = 1'b1; n_phase = PH_WHIGH; n_delay = hp; end
                PH_WHIGH: begin n_scl = 1'b0; n_phase = PH_WTAIL; n_delay = hp; end
                PH_WTAIL: begin
                    n_bit = bit_inc;
                    if (bit_inc >= 4'd8) begin
                        n_phase = PH_IDLE; n_delay = '0; done = 1'b1;
                    end else begin
                        n_sda = r_shift[BYTE_W-1];
                        n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                        n_phase = PH_WLOW; n_delay = hp;
                    end
                end
                PH_RLOW: begin
                    n_scl = 1'b1;
                    n_shift = {r_shift[BYTE_W-2:0], i_item.sda_in};
                    n_phase = PH_RHIGH; n_delay = hp;
                end
                PH_RHIGH: begin
                    n_bit = bit_inc;
                    n_scl = 1'b0;
                    n_delay = hp;
                    if (bit_inc >= 4'd8) begin
                        n_rx = r_shift;
                        n_sda = !r_ackc;
                        n_phase = PH_ALOW;
                    end else begin
                        n_phase = PH_RLOW;
                    end
                end
                PH_ALOW:  begin n_scl = 1'b1; n_phase = PH_AHIGH; n_delay = hp; end
                PH_KREL:  begin n_scl = 1'b1; n_phase = PH_KHOLD; n_delay = HALF_W'(1); end
                PH_KHOLD: begin n_phase = PH_KPOLL; n_delay = '0; end
                PH_S2, PH_AHIGH: begin
                    n_scl = 1'b0;
                    n_phase = PH_IDLE; n_delay = '0; done = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE; n_delay = '0; done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_delay <= '0;
            r_wait  <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_rx    <= '0;
            r_ackc  <= 1'b0;
            r_fail  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_delay <= n_delay;
            r_wait  <= n_wait;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rx    <= n_rx;
            r_ackc  <= n_ackc;
            r_fail  <= n_fail;
        end
    end

    assign o_res.scl_level  = n_scl;
    assign o_res.sda_level  = n_sda;
    assign o_res.busy_res   = (n_phase != PH_IDLE);
    assign o_res.done_res   = done;
    assign o_res.rx_byte    = n_rx;
    assign o_res.ack_failed = n_fail;

endmodule

`default_nettype wire
